// ----- rtl/clge_pkg.sv -----
package clge_pkg;

    // Phase of the instruction in progress: which access of it is pending.
    typedef enum logic [1:0] {
        PH_FETCH  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2,
        PH_FOURTH = 2'd3
    } t_phase;

    // Architectural and sequencing state of the core.
    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [7:0]  op;
        t_phase      phase;
        logic [7:0]  lo;
        logic [31:0] cyc;
        logic        fault;
    } t_core;

    // One result beat; the first field sits in the highest bits.
    typedef struct packed {
        logic [31:0] cycle_count;
        logic [15:0] hl_value;
        logic [15:0] de_value;
        logic [15:0] bc_value;
        logic [7:0]  acc_value;
        logic [15:0] pc_value;
        logic        fault;
        logic        instr_done;
        logic [7:0]  bus_write_data;
        logic        bus_write;
        logic [15:0] bus_address;
    } t_result;

    localparam int RESULT_W   = $bits(t_result);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

    // Register values after reset.
    localparam logic [15:0] RST_PC = 16'h0100;
    localparam logic [7:0]  RST_A  = 8'h01;
    localparam logic [7:0]  RST_B  = 8'h00;
    localparam logic [7:0]  RST_C  = 8'h13;
    localparam logic [7:0]  RST_D  = 8'h00;
    localparam logic [7:0]  RST_E  = 8'hD8;
    localparam logic [7:0]  RST_H  = 8'h01;
    localparam logic [7:0]  RST_L  = 8'h4D;

    // High page base.
    localparam logic [7:0] HIGH_PAGE = 8'hFF;

    // Top two opcode bits: register move group and immediate/indirect group.
    localparam logic [1:0] GRP_IMM  = 2'b00;
    localparam logic [1:0] GRP_MOVE = 2'b01;

    // Register index codes inside an opcode.
    localparam logic [2:0] REG_B   = 3'd0;
    localparam logic [2:0] REG_C   = 3'd1;
    localparam logic [2:0] REG_D   = 3'd2;
    localparam logic [2:0] REG_E   = 3'd3;
    localparam logic [2:0] REG_H   = 3'd4;
    localparam logic [2:0] REG_L   = 3'd5;
    localparam logic [2:0] REG_MEM = 3'd6;
    localparam logic [2:0] REG_A   = 3'd7;

    // Opcodes.
    localparam logic [7:0] OP_HALT     = 8'h76;
    localparam logic [7:0] OP_LD_HL_N  = 8'h36;
    localparam logic [7:0] OP_LD_A_NN  = 8'hFA;
    localparam logic [7:0] OP_LD_NN_A  = 8'hEA;
    localparam logic [7:0] OP_LDH_A_N  = 8'hF0;
    localparam logic [7:0] OP_LDH_N_A  = 8'hE0;
    localparam logic [7:0] OP_LD_A_BC  = 8'h0A;
    localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
    localparam logic [7:0] OP_LDH_A_C  = 8'hF2;
    localparam logic [7:0] OP_LD_BC_A  = 8'h02;
    localparam logic [7:0] OP_LD_DE_A  = 8'h12;
    localparam logic [7:0] OP_LDH_C_A  = 8'hE2;
    localparam logic [7:0] OP_LD_A_HLI = 8'h2A;
    localparam logic [7:0] OP_LD_A_HLD = 8'h3A;
    localparam logic [7:0] OP_LD_HLI_A = 8'h22;
    localparam logic [7:0] OP_LD_HLD_A = 8'h32;

endpackage

// ----- rtl/clge_step.sv -----
module clge_step
    import clge_pkg::*;
(
    input  t_core       i_core,
    input  logic [7:0]  i_data,
    output t_core       o_core,
    output t_result     o_result
);

    typedef enum logic [3:0] {
        K_MOV,
        K_LD_R_HL,
        K_ST_HL_R,
        K_LD_R_N,
        K_ST_HL_N,
        K_LD_A_NN,
        K_ST_NN_A,
        K_LDH_A_N,
        K_LDH_N_A,
        K_LD_A_RR,
        K_ST_RR_A,
        K_LD_A_HLI,
        K_LD_A_HLD,
        K_ST_HLI_A,
        K_ST_HLD_A,
        K_BAD
    } t_kind;

    function automatic t_kind op_kind(input logic [7:0] op);
        t_kind k;
        k = K_BAD;
        if (op[7:6] == GRP_MOVE && op != OP_HALT) begin
            if (op[2:0] == REG_MEM) begin
                k = K_LD_R_HL;
            end else if (op[5:3] == REG_MEM) begin
                k = K_ST_HL_R;
            end else begin
                k = K_MOV;
            end
        end else if (op[7:6] == GRP_IMM && op[2:0] == REG_MEM && op[5:3] != REG_MEM) begin
            k = K_LD_R_N;
        end else begin
            case (op)
                OP_LD_HL_N:  k = K_ST_HL_N;
                OP_LD_A_NN:  k = K_LD_A_NN;
                OP_LD_NN_A:  k = K_ST_NN_A;
                OP_LDH_A_N:  k = K_LDH_A_N;
                OP_LDH_N_A:  k = K_LDH_N_A;
                OP_LD_A_BC:  k = K_LD_A_RR;
                OP_LD_A_DE:  k = K_LD_A_RR;
                OP_LDH_A_C:  k = K_LD_A_RR;
                OP_LD_BC_A:  k = K_ST_RR_A;
                OP_LD_DE_A:  k = K_ST_RR_A;
                OP_LDH_C_A:  k = K_ST_RR_A;
                OP_LD_A_HLI: k = K_LD_A_HLI;
                OP_LD_A_HLD: k = K_LD_A_HLD;
                OP_LD_HLI_A: k = K_ST_HLI_A;
                OP_LD_HLD_A: k = K_ST_HLD_A;
                default:     k = K_BAD;
            endcase
        end
        return k;
    endfunction

    function automatic logic [7:0] get_reg(input t_core s, input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            REG_B:   v = s.b;
            REG_C:   v = s.c;
            REG_D:   v = s.d;
            REG_E:   v = s.e;
            REG_H:   v = s.h;
            REG_L:   v = s.l;
            REG_A:   v = s.a;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic t_core set_reg(input t_core s, input logic [2:0] idx,
                                      input logic [7:0] v);
        t_core r;
        r = s;
        case (idx)
            REG_B:   r.b = v;
            REG_C:   r.c = v;
            REG_D:   r.d = v;
            REG_E:   r.e = v;
            REG_H:   r.h = v;
            REG_L:   r.l = v;
            REG_A:   r.a = v;
            default: r = s;
        endcase
        return r;
    endfunction

    // Address of the register-pair and high-page C forms.
    function automatic logic [15:0] rr_addr(input t_core s);
        logic [15:0] addr;
        case (s.op)
            OP_LD_A_BC: addr = {s.b, s.c};
            OP_LD_BC_A: addr = {s.b, s.c};
            OP_LD_A_DE: addr = {s.d, s.e};
            OP_LD_DE_A: addr = {s.d, s.e};
            default:    addr = {HIGH_PAGE, s.c};
        endcase
        return addr;
    endfunction

    t_core       fs;
    t_kind       kind;
    t_core       n_core;
    logic [15:0] hl;

    // During a fetch the byte just read is the opcode.
    always_comb begin
        fs    = i_core;
        fs.op = (i_core.phase == PH_FETCH) ? i_data : i_core.op;
    end

    assign kind = op_kind(fs.op);
    assign hl   = {i_core.h, i_core.l};

    // Next register and sequencing state.
    always_comb begin
        n_core = i_core;
        if (!i_core.fault) begin
            case (i_core.phase)
                PH_FETCH: begin
                    n_core.op    = i_data;
                    n_core.pc    = i_core.pc + 16'd1;
                    n_core.phase = PH_SECOND;
                    if (kind == K_MOV) begin
                        n_core       = set_reg(n_core, i_data[5:3], get_reg(i_core, i_data[2:0]));
                        n_core.cyc   = i_core.cyc + 32'd1;
                        n_core.phase = PH_FETCH;
                    end else if (kind == K_BAD) begin
                        n_core.fault = 1'b1;
                        n_core.phase = PH_FETCH;
                    end
                end
                PH_SECOND: begin
                    n_core.phase = PH_FETCH;
                    case (kind)
                        K_LD_R_HL: begin
                            n_core     = set_reg(n_core, i_core.op[5:3], i_data);
                            n_core.cyc = i_core.cyc + 32'd2;
                        end
                        K_ST_HL_R, K_LD_A_RR, K_ST_RR_A: begin
                            n_core.cyc = i_core.cyc + 32'd2;
                            if (kind == K_LD_A_RR) begin
                                n_core.a = i_data;
                            end
                        end
                        K_LD_R_N: begin
                            n_core     = set_reg(n_core, i_core.op[5:3], i_data);
                            n_core.pc  = i_core.pc + 16'd1;
                            n_core.cyc = i_core.cyc + 32'd2;
                        end
                        K_ST_HL_N, K_LD_A_NN, K_ST_NN_A: begin
                            n_core.lo    = i_data;
                            n_core.pc    = i_core.pc + 16'd1;
                            n_core.phase = PH_THIRD;
                        end
                        K_LDH_A_N, K_LDH_N_A: begin
                            n_core.pc    = i_core.pc + 16'd1;
                            n_core.phase = PH_THIRD;
                        end
                        K_LD_A_HLI, K_ST_HLI_A: begin
                            {n_core.h, n_core.l} = hl + 16'd1;
                            n_core.cyc           = i_core.cyc + 32'd2;
                            if (kind == K_LD_A_HLI) begin
                                n_core.a = i_data;
                            end
                        end
                        K_LD_A_HLD, K_ST_HLD_A: begin
                            {n_core.h, n_core.l} = hl - 16'd1;
                            n_core.cyc           = i_core.cyc + 32'd2;
                            if (kind == K_LD_A_HLD) begin
                                n_core.a = i_data;
                            end
                        end
                        default: n_core.phase = PH_FETCH;
                    endcase
                end
                PH_THIRD: begin
                    n_core.phase = PH_FETCH;
                    case (kind)
                        K_ST_HL_N, K_LDH_N_A: n_core.cyc = i_core.cyc + 32'd3;
                        K_LDH_A_N: begin
                            n_core.a   = i_data;
                            n_core.cyc = i_core.cyc + 32'd3;
                        end
                        K_LD_A_NN, K_ST_NN_A: begin
                            n_core.pc    = i_core.pc + 16'd1;
                            n_core.phase = PH_FOURTH;
                        end
                        default: n_core.phase = PH_FETCH;
                    endcase
                end
                default: begin
                    n_core.phase = PH_FETCH;
                    if (kind == K_LD_A_NN) begin
                        n_core.a   = i_data;
                        n_core.cyc = i_core.cyc + 32'd4;
                    end else if (kind == K_ST_NN_A) begin
                        n_core.cyc = i_core.cyc + 32'd4;
                    end
                end
            endcase
        end
    end

    // Next bus access; by default a read at the new program counter.
    always_comb begin
        o_result.bus_address    = n_core.pc;
        o_result.bus_write      = 1'b0;
        o_result.bus_write_data = 8'h00;
        o_result.instr_done     = 1'b0;
        if (!i_core.fault) begin
            case (i_core.phase)
                PH_FETCH: begin
                    case (kind)
                        K_MOV: o_result.instr_done = 1'b1;
                        K_LD_R_HL, K_LD_A_HLI, K_LD_A_HLD: o_result.bus_address = hl;
                        K_ST_HL_R: begin
                            o_result.bus_address    = hl;
                            o_result.bus_write      = 1'b1;
                            o_result.bus_write_data = get_reg(i_core, i_data[2:0]);
                        end
                        K_ST_HLI_A, K_ST_HLD_A: begin
                            o_result.bus_address    = hl;
                            o_result.bus_write      = 1'b1;
                            o_result.bus_write_data = i_core.a;
                        end
                        K_LD_A_RR: o_result.bus_address = rr_addr(fs);
                        K_ST_RR_A: begin
                            o_result.bus_address    = rr_addr(fs);
                            o_result.bus_write      = 1'b1;
                            o_result.bus_write_data = i_core.a;
                        end
                        default: o_result.bus_write = 1'b0;
                    endcase
                end
                PH_SECOND: begin
                    case (kind)
                        K_ST_HL_N: begin
                            o_result.bus_address    = hl;
                            o_result.bus_write      = 1'b1;
                            o_result.bus_write_data = i_data;
                        end
                        K_LDH_A_N: o_result.bus_address = {HIGH_PAGE, i_data};
                        K_LDH_N_A: begin
                            o_result.bus_address    = {HIGH_PAGE, i_data};
                            o_result.bus_write      = 1'b1;
                            o_result.bus_write_data = i_core.a;
                        end
                        K_LD_A_NN, K_ST_NN_A: o_result.instr_done = 1'b0;
                        K_MOV, K_BAD: o_result.instr_done = 1'b0;
                        default: o_result.instr_done = 1'b1;
                    endcase
                end
                PH_THIRD: begin
                    case (kind)
                        K_ST_HL_N, K_LDH_N_A, K_LDH_A_N: o_result.instr_done = 1'b1;
                        K_LD_A_NN: o_result.bus_address = {i_data, i_core.lo};
                        K_ST_NN_A: begin
                            o_result.bus_address    = {i_data, i_core.lo};
                            o_result.bus_write      = 1'b1;
                            o_result.bus_write_data = i_core.a;
                        end
                        default: o_result.instr_done = 1'b0;
                    endcase
                end
                default: begin
                    o_result.instr_done = (kind == K_LD_A_NN) || (kind == K_ST_NN_A);
                end
            endcase
        end
        if (n_core.fault) begin
            o_result.bus_address    = n_core.pc;
            o_result.bus_write      = 1'b0;
            o_result.bus_write_data = 8'h00;
            o_result.instr_done     = 1'b0;
        end

        // Register view after this beat.
        o_result.fault       = n_core.fault;
        o_result.pc_value    = n_core.pc;
        o_result.acc_value   = n_core.a;
        o_result.bc_value    = {n_core.b, n_core.c};
        o_result.de_value    = {n_core.d, n_core.e};
        o_result.hl_value    = {n_core.h, n_core.l};
        o_result.cycle_count = n_core.cyc;
    end

    assign o_core = n_core;

endmodule

// ----- rtl/cpu_load_group_executor_core.sv -----
// Channel   Dir  Bits  Contents
// s_axis    in   8     bus_read_data
// m_axis    out  136   next access, done/fault flags, register view, cycle count
//
// Each accepted bus beat is handled by the step logic, which sits between the
// state registers and the result register, so one beat per cycle is sustained
// while m_axis is not stalled. Each result is registered in the output buffer.
// Reset (synchronous, active low) restores the power-on registers with an opcode
// fetch pending at 0x0100; no result is shown until the first input beat arrives.
// A two-entry output buffer (result register plus skid) keeps s_axis open for one
// more beat while m_axis is stalled; after that s_tready drops until a beat leaves.
module cpu_load_group_executor_core
    import clge_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] bus_read_data
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] bus_address, [16] bus_write, [24:17] bus_write_data, [25] instr_done,
    // [26] fault, [42:27] pc_value, [50:43] acc_value, [66:51] bc_value,
    // [82:67] de_value, [98:83] hl_value, [130:99] cycle_count, [135:131] zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    t_core   r_core;
    t_core   n_core;
    t_result n_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_fire;
    logic    out_fire;

    clge_step u_step (
        .i_core   (r_core),
        .i_data   (s_tdata),
        .o_core   (n_core),
        .o_result (n_result)
    );

    assign s_tready = !r_skid_valid;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = r_out_valid && m_tready;

    // Core state advances on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core.pc    <= RST_PC;
            r_core.a     <= RST_A;
            r_core.b     <= RST_B;
            r_core.c     <= RST_C;
            r_core.d     <= RST_D;
            r_core.e     <= RST_E;
            r_core.h     <= RST_H;
            r_core.l     <= RST_L;
            r_core.op    <= 8'h00;
            r_core.phase <= PH_FETCH;
            r_core.lo    <= 8'h00;
            r_core.cyc   <= 32'd0;
            r_core.fault <= 1'b0;
        end else if (in_fire) begin
            r_core <= n_core;
        end
    end

    // Output buffer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    // Output buffer payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end else if (out_fire && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, r_out};

endmodule

// ----- rtl/clge_checker.sv -----
module clge_checker
    import clge_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata
);

    t_result     res;
    logic        out_beat;
    logic        r_seen_fault;
    logic [31:0] r_last_cyc;

    assign res      = t_result'(m_tdata[RESULT_W-1:0]);
    assign out_beat = m_tvalid && m_tready;

    // Track what earlier result beats showed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_fault <= 1'b0;
            r_last_cyc   <= 32'd0;
        end else if (out_beat) begin
            r_seen_fault <= r_seen_fault || res.fault;
            r_last_cyc   <= res.cycle_count;
        end
    end

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // The input is refused only while a result is waiting.
    a_refuse_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && !s_tready |-> m_tvalid)
        else $error("input refused with no result waiting");

    // The fault flag never clears once shown.
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_seen_fault |-> res.fault)
        else $error("fault cleared");

    // The cycle count moves only when an instruction completes.
    a_cyc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && !res.instr_done |-> res.cycle_count == r_last_cyc)
        else $error("cycle count moved without completion");

    // After a completion or a fault the next access is a read at the PC.
    a_fetch_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && (res.instr_done || res.fault) |->
            !res.bus_write && res.bus_address == res.pc_value)
        else $error("next access is not a fetch at the PC");

endmodule

bind cpu_load_group_executor_core clge_checker u_clge_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/clge_result_monitor.sv -----
module clge_result_monitor
    import clge_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] bus_read_data
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // [15:0] bus_address, [16] bus_write, [24:17] bus_write_data, [25] instr_done,
    // [26] fault, [42:27] pc_value, [50:43] acc_value, [66:51] bc_value,
    // [82:67] de_value, [98:83] hl_value, [130:99] cycle_count, [135:131] zero
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    output int                    o_errors,
    output int                    o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the core's registers and sequencing state.
    logic [15:0] arch_pc;
    logic [7:0]  gpr [8];
    logic [7:0]  cur_op;
    logic [7:0]  op_lo;
    t_phase      step_ph;
    logic [31:0] mcycles;
    logic        stopped;

    // Next bus access formed during one step.
    logic [15:0] acc_addr;
    logic        acc_wr;
    logic [7:0]  acc_wdata;
    logic        acc_done;

    t_result     access_queue [$];
    int          errors;
    int          queued;

    assign o_errors  = errors;
    assign o_pending = queued;

    task automatic restore_core();
        arch_pc       = RST_PC;
        gpr[REG_A]    = RST_A;
        gpr[REG_B]    = RST_B;
        gpr[REG_C]    = RST_C;
        gpr[REG_D]    = RST_D;
        gpr[REG_E]    = RST_E;
        gpr[REG_H]    = RST_H;
        gpr[REG_L]    = RST_L;
        gpr[REG_MEM]  = 8'h00;
        cur_op        = 8'h00;
        op_lo         = 8'h00;
        step_ph       = PH_FETCH;
        mcycles       = 32'd0;
        stopped       = 1'b0;
    endtask

    task automatic bus_rd(input logic [15:0] a, input t_phase p);
        acc_addr  = a;
        acc_wr    = 1'b0;
        acc_wdata = 8'h00;
        step_ph   = p;
    endtask

    task automatic bus_wr(input logic [15:0] a, input logic [7:0] dat, input t_phase p);
        acc_addr  = a;
        acc_wr    = 1'b1;
        acc_wdata = dat;
        step_ph   = p;
    endtask

    // Instruction completes: count its machine cycles and fetch the next opcode.
    task automatic retire(input logic [31:0] n);
        mcycles  = mcycles + n;
        acc_done = 1'b1;
        bus_rd(arch_pc, PH_FETCH);
    endtask

    // Consume one bus byte and work out the access and register view it leads to.
    task automatic advance_core(input logic [7:0] d, output t_result r);
        logic [15:0] hl;
        logic [2:0]  dst;
        logic [2:0]  src;
        hl       = {gpr[REG_H], gpr[REG_L]};
        acc_done = 1'b0;
        if (!stopped) begin
            case (step_ph)
                PH_FETCH: begin
                    cur_op  = d;
                    arch_pc = arch_pc + 16'd1;
                    dst     = d[5:3];
                    src     = d[2:0];
                    if (d[7:6] == GRP_MOVE && d != OP_HALT) begin
                        if (src == REG_MEM) begin
                            bus_rd(hl, PH_SECOND);
                        end else if (dst == REG_MEM) begin
                            bus_wr(hl, gpr[src], PH_SECOND);
                        end else begin
                            gpr[dst] = gpr[src];
                            retire(32'd1);
                        end
                    end else if (d[7:6] == GRP_IMM && src == REG_MEM) begin
                        bus_rd(arch_pc, PH_SECOND);
                    end else begin
                        case (d)
                            OP_LD_A_NN, OP_LD_NN_A, OP_LDH_A_N, OP_LDH_N_A:
                                bus_rd(arch_pc, PH_SECOND);
                            OP_LD_A_BC: bus_rd({gpr[REG_B], gpr[REG_C]}, PH_SECOND);
                            OP_LD_A_DE: bus_rd({gpr[REG_D], gpr[REG_E]}, PH_SECOND);
                            OP_LD_BC_A: bus_wr({gpr[REG_B], gpr[REG_C]}, gpr[REG_A], PH_SECOND);
                            OP_LD_DE_A: bus_wr({gpr[REG_D], gpr[REG_E]}, gpr[REG_A], PH_SECOND);
                            OP_LDH_A_C: bus_rd({HIGH_PAGE, gpr[REG_C]}, PH_SECOND);
                            OP_LDH_C_A: bus_wr({HIGH_PAGE, gpr[REG_C]}, gpr[REG_A], PH_SECOND);
                            OP_LD_A_HLI, OP_LD_A_HLD: bus_rd(hl, PH_SECOND);
                            OP_LD_HLI_A, OP_LD_HLD_A: bus_wr(hl, gpr[REG_A], PH_SECOND);
                            default: begin
                                stopped = 1'b1;
                                bus_rd(arch_pc, PH_FETCH);
                            end
                        endcase
                    end
                end
                PH_SECOND: begin
                    if (cur_op[7:6] == GRP_MOVE && cur_op != OP_HALT) begin
                        if (cur_op[2:0] == REG_MEM) gpr[cur_op[5:3]] = d;
                        retire(32'd2);
                    end else if (cur_op[7:6] == GRP_IMM && cur_op[2:0] == REG_MEM) begin
                        arch_pc = arch_pc + 16'd1;
                        if (cur_op == OP_LD_HL_N) begin
                            op_lo = d;
                            bus_wr(hl, d, PH_THIRD);
                        end else begin
                            gpr[cur_op[5:3]] = d;
                            retire(32'd2);
                        end
                    end else begin
                        case (cur_op)
                            OP_LD_A_NN, OP_LD_NN_A: begin
                                op_lo   = d;
                                arch_pc = arch_pc + 16'd1;
                                bus_rd(arch_pc, PH_THIRD);
                            end
                            OP_LDH_A_N: begin
                                arch_pc = arch_pc + 16'd1;
                                bus_rd({HIGH_PAGE, d}, PH_THIRD);
                            end
                            OP_LDH_N_A: begin
                                arch_pc = arch_pc + 16'd1;
                                bus_wr({HIGH_PAGE, d}, gpr[REG_A], PH_THIRD);
                            end
                            OP_LD_A_BC, OP_LD_A_DE, OP_LDH_A_C: begin
                                gpr[REG_A] = d;
                                retire(32'd2);
                            end
                            OP_LD_BC_A, OP_LD_DE_A, OP_LDH_C_A: retire(32'd2);
                            OP_LD_A_HLI: begin
                                gpr[REG_A] = d;
                                {gpr[REG_H], gpr[REG_L]} = hl + 16'd1;
                                retire(32'd2);
                            end
                            OP_LD_A_HLD: begin
                                gpr[REG_A] = d;
                                {gpr[REG_H], gpr[REG_L]} = hl - 16'd1;
                                retire(32'd2);
                            end
                            OP_LD_HLI_A: begin
                                {gpr[REG_H], gpr[REG_L]} = hl + 16'd1;
                                retire(32'd2);
                            end
                            OP_LD_HLD_A: begin
                                {gpr[REG_H], gpr[REG_L]} = hl - 16'd1;
                                retire(32'd2);
                            end
                            default: bus_rd(arch_pc, PH_FETCH);
                        endcase
                    end
                end
                PH_THIRD: begin
                    case (cur_op)
                        OP_LD_HL_N, OP_LDH_N_A: retire(32'd3);
                        OP_LDH_A_N: begin
                            gpr[REG_A] = d;
                            retire(32'd3);
                        end
                        OP_LD_A_NN: begin
                            arch_pc = arch_pc + 16'd1;
                            bus_rd({d, op_lo}, PH_FOURTH);
                        end
                        OP_LD_NN_A: begin
                            arch_pc = arch_pc + 16'd1;
                            bus_wr({d, op_lo}, gpr[REG_A], PH_FOURTH);
                        end
                        default: bus_rd(arch_pc, PH_FETCH);
                    endcase
                end
                default: begin
                    if (cur_op == OP_LD_A_NN) begin
                        gpr[REG_A] = d;
                        retire(32'd4);
                    end else if (cur_op == OP_LD_NN_A) begin
                        retire(32'd4);
                    end else begin
                        bus_rd(arch_pc, PH_FETCH);
                    end
                end
            endcase
        end

        // A stopped core keeps offering a plain read at the program counter.
        if (stopped) begin
            acc_addr  = arch_pc;
            acc_wr    = 1'b0;
            acc_wdata = 8'h00;
            acc_done  = 1'b0;
        end

        r.bus_address    = acc_addr;
        r.bus_write      = acc_wr;
        r.bus_write_data = acc_wdata;
        r.instr_done     = acc_done;
        r.fault          = stopped;
        r.pc_value       = arch_pc;
        r.acc_value      = gpr[REG_A];
        r.bc_value       = {gpr[REG_B], gpr[REG_C]};
        r.de_value       = {gpr[REG_D], gpr[REG_E]};
        r.hl_value       = {gpr[REG_H], gpr[REG_L]};
        r.cycle_count    = mcycles;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors = errors + 1;
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Compare each result beat with the oldest prediction, then predict from
    // the input beat taken at the same edge.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            restore_core();
            access_queue.delete();
            errors = 0;
            queued = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[RESULT_W-1:0]);
                if (access_queue.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t ns: result beat with nothing expected, got %0h",
                             $time, got);
                end else begin
                    want = access_queue.pop_front();
                    check_field("bus_address", 32'(want.bus_address), 32'(got.bus_address));
                    check_field("bus_write", 32'(want.bus_write), 32'(got.bus_write));
                    check_field("bus_write_data", 32'(want.bus_write_data),
                                32'(got.bus_write_data));
                    check_field("instr_done", 32'(want.instr_done), 32'(got.instr_done));
                    check_field("fault", 32'(want.fault), 32'(got.fault));
                    check_field("pc_value", 32'(want.pc_value), 32'(got.pc_value));
                    check_field("acc_value", 32'(want.acc_value), 32'(got.acc_value));
                    check_field("bc_value", 32'(want.bc_value), 32'(got.bc_value));
                    check_field("de_value", 32'(want.de_value), 32'(got.de_value));
                    check_field("hl_value", 32'(want.hl_value), 32'(got.hl_value));
                    check_field("cycle_count", want.cycle_count, got.cycle_count);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_core(i_s_tdata, want);
                access_queue.push_back(want);
            end
            queued = access_queue.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import clge_pkg::*;

    localparam int RANDOM_BEATS = 950;
    localparam int PRESSURE_AT  = 300;
    localparam int BURST_FROM   = 600;
    localparam int BURST_TO     = 700;
    localparam int HOLD_CYCLES  = 200;
    localparam int STOPPED_BEATS = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_CYCLES = 500000;

    // Opcodes that the register move group and the LD r,n form do not cover.
    localparam logic [7:0] DATA_OPS [15] = '{
        OP_LD_HL_N, OP_LD_A_NN, OP_LD_NN_A, OP_LDH_A_N, OP_LDH_N_A,
        OP_LD_A_BC, OP_LD_A_DE, OP_LDH_A_C, OP_LD_BC_A, OP_LD_DE_A,
        OP_LDH_C_A, OP_LD_A_HLI, OP_LD_A_HLD, OP_LD_HLI_A, OP_LD_HLD_A
    };

    logic                  i_clk;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;   // [7:0] bus_read_data
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [15:0] bus_address, [16] bus_write, [24:17] bus_write_data, [25] instr_done,
    // [26] fault, [42:27] pc_value, [50:43] acc_value, [66:51] bc_value,
    // [82:67] de_value, [98:83] hl_value, [130:99] cycle_count, [135:131] zero
    logic [OUT_DATA_W-1:0] m_tdata;

    int   fail_count;
    int   pending;
    int   beats_sent = 0;
    logic burst      = 1'b0;
    logic hold_req   = 1'b0;
    logic hold_taken = 1'b0;
    int   rx_wait    = 0;
    int   cycles     = 0;

    cpu_load_group_executor_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    clge_result_monitor u_monitor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (fail_count),
        .o_pending  (pending)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, none during the burst window, and one long hold-off.
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            rx_wait = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (burst) begin
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                rx_wait = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    // Number of bus beats that follow the opcode fetch, or -1 outside the group.
    function automatic int access_count(logic [7:0] op);
        if (op[7:6] == GRP_MOVE && op != OP_HALT)
            return (op[2:0] == REG_MEM || op[5:3] == REG_MEM) ? 1 : 0;
        if (op[7:6] == GRP_IMM && op[2:0] == REG_MEM)
            return (op == OP_LD_HL_N) ? 2 : 1;
        case (op)
            OP_LD_A_NN, OP_LD_NN_A: return 3;
            OP_LDH_A_N, OP_LDH_N_A: return 2;
            OP_LD_A_BC, OP_LD_A_DE, OP_LDH_A_C, OP_LD_BC_A, OP_LD_DE_A, OP_LDH_C_A,
            OP_LD_A_HLI, OP_LD_A_HLD, OP_LD_HLI_A, OP_LD_HLD_A: return 1;
            default: return -1;
        endcase
    endfunction

    // Offer one bus byte after a random gap and wait until it is taken.
    task automatic send_beat(input logic [7:0] d);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 70) gap = 0;
        else if (r < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge i_clk); while (!s_tready);
        beats_sent = beats_sent + 1;
        burst = (beats_sent >= BURST_FROM && beats_sent < BURST_TO);
        if (beats_sent == PRESSURE_AT) hold_req <= 1'b1;
    endtask

    // One complete instruction with random operand and data bytes.
    task automatic send_instr(input logic [7:0] op);
        send_beat(op);
        repeat (access_count(op)) send_beat(8'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [7:0] op;
        int total;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: move, HL-indirect, absolute, high-page and immediate forms, byte extremes, HL wrapping both ways.
        send_beat({GRP_MOVE, REG_B, REG_C});
        send_beat({GRP_MOVE, REG_A, REG_MEM});
        send_beat(8'hFF);
        send_beat(OP_LD_HL_N);
        send_beat(8'h00);
        send_beat(8'hFF);
        send_beat(OP_LD_A_NN);
        send_beat(8'h00);
        send_beat(8'hFF);
        send_beat(8'hA5);
        send_beat(OP_LD_NN_A);
        send_beat(8'hFF);
        send_beat(8'h00);
        send_beat(8'h00);
        send_beat(OP_LDH_A_N);
        send_beat(8'hFF);
        send_beat(8'h5A);
        send_beat({GRP_IMM, REG_H, REG_MEM});
        send_beat(8'h00);
        send_beat({GRP_IMM, REG_L, REG_MEM});
        send_beat(8'h00);
        send_beat(OP_LD_HLD_A);
        send_beat(8'hFF);
        send_beat(OP_LD_A_HLI);
        send_beat(8'h00);

        // Random well-formed instruction stream.
        total = beats_sent + RANDOM_BEATS;
        while (beats_sent < total) begin
            if ($urandom_range(0, 1) == 0) begin
                do op = 8'($urandom_range(0, 255)); while (access_count(op) < 0);
            end else begin
                op = DATA_OPS[4'($urandom_range(0, 14))];
            end
            send_instr(op);
        end

        // An undefined opcode stops the core; later bytes must change nothing.
        if ($urandom_range(0, 1) == 0) begin
            op = OP_HALT;
        end else begin
            do op = 8'($urandom_range(0, 255)); while (access_count(op) >= 0);
        end
        send_beat(op);
        repeat (STOPPED_BEATS) send_beat(8'($urandom_range(0, 255)));
        s_tvalid <= 1'b0;

        // Drain the remaining results, then watch for stray beats.
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- cpu_load_group_executor_core.f -----
rtl/clge_pkg.sv
rtl/clge_step.sv
rtl/cpu_load_group_executor_core.sv
rtl/clge_checker.sv
tb/clge_result_monitor.sv
tb/tb.sv
